FILE: hw/rtl/hnk_pkg.sv
// Package for the top-N heap keeper: field widths, opcodes, register indexes,
// sequencer states and the memory control struct.
// No dependencies; every other file of the block imports it.
package hnk_pkg;

  localparam int DEF_CAPACITY      = 64;
  localparam int DEF_KEY_WIDTH     = 32;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  localparam int OPCODE_WIDTH    = 2;
  localparam int INDEX_WIDTH     = $clog2(DEF_CAPACITY);
  localparam int COUNT_WIDTH     = $clog2(DEF_CAPACITY + 1);
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = COUNT_WIDTH;

  localparam logic [COUNT_WIDTH-1:0] CAPACITY_RESET = COUNT_WIDTH'(DEF_CAPACITY);

  typedef enum logic [OPCODE_WIDTH-1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_IGNORE = 2'd3
  } op_t;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ORDER    = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UP,
    ST_FIN,
    ST_ROOT,
    ST_DN_SEL,
    ST_DN_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

FILE: hw/rtl/hnk_req_if.sv
// Request channel interface of the heap keeper: valid, ready and one item.
// Depends on hnk_pkg for the opcode and index widths.
interface hnk_req_if #(
  parameter int KEY_WIDTH     = hnk_pkg::DEF_KEY_WIDTH,
  parameter int PAYLOAD_WIDTH = hnk_pkg::DEF_PAYLOAD_WIDTH
);
  import hnk_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OPCODE_WIDTH-1:0]  opcode;
  logic [KEY_WIDTH-1:0]     key;
  logic [PAYLOAD_WIDTH-1:0] payload;
  logic [INDEX_WIDTH-1:0]   index;

  modport source (output valid, opcode, key, payload, index, input ready);
  modport sink   (input valid, opcode, key, payload, index, output ready);
endinterface

FILE: hw/rtl/hnk_rsp_if.sv
// Response channel interface of the heap keeper: valid, ready and one result.
// Depends on hnk_pkg for the count width.
interface hnk_rsp_if #(
  parameter int KEY_WIDTH     = hnk_pkg::DEF_KEY_WIDTH,
  parameter int PAYLOAD_WIDTH = hnk_pkg::DEF_PAYLOAD_WIDTH
);
  import hnk_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic [COUNT_WIDTH-1:0]   count;
  logic                     read_valid;
  logic [KEY_WIDTH-1:0]     read_key;
  logic [PAYLOAD_WIDTH-1:0] read_payload;

  modport source (output valid, accepted, count, read_valid, read_key, read_payload,
                  input ready);
  modport sink   (input valid, accepted, count, read_valid, read_key, read_payload,
                  output ready);
endinterface

FILE: hw/rtl/hnk_cfg_if.sv
// Configuration write channel of the heap keeper: valid, ready, index, data.
// Depends on hnk_pkg for the index and data widths.
interface hnk_cfg_if;
  import hnk_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/hnk_store.sv
// Record memory of the heap keeper: one write port, two registered read ports.
// Depends on hnk_pkg for the memory control struct.
module hnk_store #(
  parameter int CAPACITY   = hnk_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = hnk_pkg::DEF_KEY_WIDTH + hnk_pkg::DEF_PAYLOAD_WIDTH
) (
  input  logic                        clk,
  input  hnk_pkg::mem_ctl_t           ctl,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  logic [DATA_WIDTH-1:0]       wr_data,
  input  logic [$clog2(CAPACITY)-1:0] rd_a_addr,
  input  logic [$clog2(CAPACITY)-1:0] rd_b_addr,
  output logic [DATA_WIDTH-1:0]       rd_a_data,
  output logic [DATA_WIDTH-1:0]       rd_b_data
);
  import hnk_pkg::*;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

FILE: hw/rtl/hnk_rank.sv
// Shared ranking comparator of the heap keeper: tells whether key a ranks worse than b.
// Depends on hnk_pkg for the default key width; the order mode selects the direction.
module hnk_rank #(
  parameter int KEY_WIDTH = hnk_pkg::DEF_KEY_WIDTH
) (
  input  logic [KEY_WIDTH-1:0] a,
  input  logic [KEY_WIDTH-1:0] b,
  input  logic                 keep_smallest,
  output logic                 worse
);
  import hnk_pkg::*;

  assign worse = keep_smallest ? (a > b) : (a < b);

endmodule

FILE: hw/rtl/hnk_seq.sv
// Sequencer of the heap keeper: takes requests, walks the heap one level per step
// through the record memory and the shared comparator, and registers the response.
// Depends on hnk_pkg, hnk_req_if and hnk_rsp_if.
module hnk_seq #(
  parameter int CAPACITY      = hnk_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH     = hnk_pkg::DEF_KEY_WIDTH,
  parameter int PAYLOAD_WIDTH = hnk_pkg::DEF_PAYLOAD_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [hnk_pkg::COUNT_WIDTH-1:0]      cap,
  hnk_req_if.sink                              req,
  hnk_rsp_if.source                            rsp,
  output hnk_pkg::mem_ctl_t                    mctl,
  output logic [$clog2(CAPACITY)-1:0]          wr_addr,
  output logic [KEY_WIDTH+PAYLOAD_WIDTH-1:0]   wr_data,
  output logic [$clog2(CAPACITY)-1:0]          rd_a_addr,
  output logic [$clog2(CAPACITY)-1:0]          rd_b_addr,
  input  logic [KEY_WIDTH+PAYLOAD_WIDTH-1:0]   rd_a_data,
  input  logic [KEY_WIDTH+PAYLOAD_WIDTH-1:0]   rd_b_data,
  output logic [KEY_WIDTH-1:0]                 rank_a,
  output logic [KEY_WIDTH-1:0]                 rank_b,
  input  logic                                 rank_worse
);
  import hnk_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int HW  = $clog2(CAPACITY + 1);
  localparam int CIW = AW + 2;
  localparam int DW  = KEY_WIDTH + PAYLOAD_WIDTH;

  state_t state;
  state_t state_next;

  logic [HW-1:0]            held;
  logic [AW-1:0]            pos;
  logic [KEY_WIDTH-1:0]     rec_key;
  logic [PAYLOAD_WIDTH-1:0] rec_pay;
  logic [AW-1:0]            child_idx;
  logic [KEY_WIDTH-1:0]     child_key;
  logic [PAYLOAD_WIDTH-1:0] child_pay;
  logic                     res_accepted;
  logic                     res_rvalid;
  logic [KEY_WIDTH-1:0]     res_key;
  logic [PAYLOAD_WIDTH-1:0] res_pay;

  logic                     acc;
  logic                     out_free;
  logic [HW-1:0]            eff_cap;
  logic                     not_full;
  logic                     idx_ok;
  logic [AW-1:0]            held_lo;
  logic [AW-1:0]            par_held;
  logic [AW-1:0]            par_pos;
  logic [AW-1:0]            par_par;
  logic [CIW-1:0]           held_x;
  logic [CIW-1:0]           cur1;
  logic [CIW-1:0]           cur2;
  logic [AW-1:0]            kid_base;
  logic [CIW-1:0]           kid1;
  logic [CIW-1:0]           kid2;
  logic                     pick_b;
  logic [KEY_WIDTH-1:0]     rd_a_key;
  logic [PAYLOAD_WIDTH-1:0] rd_a_pay;
  logic [KEY_WIDTH-1:0]     rd_b_key;
  logic [PAYLOAD_WIDTH-1:0] rd_b_pay;

  assign rd_a_key = rd_a_data[DW-1:PAYLOAD_WIDTH];
  assign rd_a_pay = rd_a_data[PAYLOAD_WIDTH-1:0];
  assign rd_b_key = rd_b_data[DW-1:PAYLOAD_WIDTH];
  assign rd_b_pay = rd_b_data[PAYLOAD_WIDTH-1:0];

  assign acc      = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;

  always_comb begin
    if (cap == '0) begin
      eff_cap = HW'(1);
    end else if (int'(cap) > CAPACITY) begin
      eff_cap = HW'(CAPACITY);
    end else begin
      eff_cap = HW'(cap);
    end
  end

  assign not_full = held < eff_cap;
  assign idx_ok   = (HW + INDEX_WIDTH)'(req.index) < (HW + INDEX_WIDTH)'(held);

  assign held_lo  = held[AW-1:0];
  assign par_held = AW'((held_lo - AW'(1)) >> 1);
  assign par_pos  = AW'((pos - AW'(1)) >> 1);
  assign par_par  = AW'((par_pos - AW'(1)) >> 1);
  assign held_x   = CIW'(held);
  assign cur1     = (CIW'(pos) << 1) + CIW'(1);
  assign cur2     = cur1 + CIW'(1);
  assign kid_base = (state == ST_ROOT) ? '0 : child_idx;
  assign kid1     = (CIW'(kid_base) << 1) + CIW'(1);
  assign kid2     = kid1 + CIW'(1);
  assign pick_b   = (cur2 < held_x) && rank_worse;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (op_t'(req.opcode))
            OP_INSERT: begin
              if (not_full) begin
                state_next = (held == '0) ? ST_FIN : ST_UP;
              end else if (held != '0) begin
                state_next = ST_ROOT;
              end else begin
                state_next = ST_DONE;
              end
            end
            OP_READ: state_next = ST_READ;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_UP: begin
        if (rank_worse && par_pos != '0) begin
          state_next = ST_UP;
        end else if (rank_worse) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FIN:    state_next = ST_DONE;
      ST_ROOT:   state_next = rank_worse ? ST_DN_SEL : ST_DONE;
      ST_DN_SEL: state_next = (cur1 >= held_x) ? ST_DONE : ST_DN_CMP;
      ST_DN_CMP: state_next = rank_worse ? ST_DN_SEL : ST_DONE;
      ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready   = (state == ST_IDLE);
    mctl.rd_en  = 1'b0;
    mctl.wr_en  = 1'b0;
    wr_addr     = pos;
    wr_data     = {rec_key, rec_pay};
    rd_a_addr   = kid1[AW-1:0];
    rd_b_addr   = kid2[AW-1:0];
    rank_a      = rec_key;
    rank_b      = rd_a_key;
    case (state)
      ST_IDLE: begin
        mctl.rd_en = acc;
        if (op_t'(req.opcode) == OP_READ) begin
          rd_a_addr = AW'(req.index);
        end else if (not_full) begin
          rd_a_addr = par_held;
        end else begin
          rd_a_addr = '0;
        end
      end
      ST_UP: begin
        mctl.wr_en = 1'b1;
        mctl.rd_en = rank_worse && par_pos != '0;
        rd_a_addr  = par_par;
        if (rank_worse) begin
          wr_data = rd_a_data;
        end
      end
      ST_FIN: begin
        mctl.wr_en = 1'b1;
      end
      ST_ROOT: begin
        mctl.rd_en = rank_worse;
        rank_a     = rd_a_key;
        rank_b     = rec_key;
      end
      ST_DN_SEL: begin
        mctl.wr_en = (cur1 >= held_x);
        rank_a     = rd_b_key;
        rank_b     = rd_a_key;
      end
      ST_DN_CMP: begin
        mctl.wr_en = 1'b1;
        mctl.rd_en = rank_worse;
        rank_a     = child_key;
        rank_b     = rec_key;
        if (rank_worse) begin
          wr_data = {child_key, child_pay};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      held      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && acc && op_t'(req.opcode) == OP_INSERT && not_full) begin
        held <= held + HW'(1);
      end else if (state == ST_IDLE && acc && op_t'(req.opcode) == OP_CLEAR) begin
        held <= '0;
      end
      if (state == ST_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (acc) begin
          rec_key      <= req.key;
          rec_pay      <= req.payload;
          res_accepted <= 1'b0;
          res_rvalid   <= 1'b0;
          res_key      <= '0;
          res_pay      <= '0;
          case (op_t'(req.opcode))
            OP_INSERT: begin
              if (not_full) begin
                pos          <= held_lo;
                res_accepted <= 1'b1;
              end else begin
                pos <= '0;
              end
            end
            OP_READ: res_rvalid <= idx_ok;
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        res_key <= res_rvalid ? rd_a_key : '0;
        res_pay <= res_rvalid ? rd_a_pay : '0;
      end
      ST_UP: begin
        if (rank_worse) begin
          pos <= par_pos;
        end
      end
      ST_ROOT: begin
        res_accepted <= rank_worse;
      end
      ST_DN_SEL: begin
        child_idx <= pick_b ? cur2[AW-1:0] : cur1[AW-1:0];
        child_key <= pick_b ? rd_b_key : rd_a_key;
        child_pay <= pick_b ? rd_b_pay : rd_a_pay;
      end
      ST_DN_CMP: begin
        if (rank_worse) begin
          pos <= child_idx;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          rsp.accepted     <= res_accepted;
          rsp.count        <= COUNT_WIDTH'(held);
          rsp.read_valid   <= res_rvalid;
          rsp.read_key     <= res_key;
          rsp.read_payload <= res_pay;
        end
      end
      default: begin
      end
    endcase
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= HW'(CAPACITY))
    else $error("held count exceeds the built capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_DONE || state == ST_READ) |-> !mctl.wr_en)
    else $error("memory write outside a sift step");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (acc && req.opcode == OP_CLEAR) |=> (held == '0))
    else $error("clear did not empty the heap");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.accepted && rsp.read_valid))
    else $error("result flags both an insert and a read");

endmodule

FILE: hw/rtl/top_n_heap_keeper.sv
// Top level of the top-N heap keeper: configuration registers, the record memory,
// the shared comparator and the sequencer. Depends on hnk_pkg, the channel
// interfaces, hnk_store, hnk_rank and hnk_seq.
// A clear or an ignored opcode goes straight to the result and a read fetches one record;
// an insert sifts the new item up level by level; a full-heap insert is dropped unless it
// ranks above the root, else it replaces the root and sifts down, select then compare per level.
// Requests are taken again in the cycle the result turns valid; a held result stalls.
// Reset clears the count and restores the registers to capacity 64, keep largest.
module top_n_heap_keeper #(
  parameter int KEY_WIDTH     = hnk_pkg::DEF_KEY_WIDTH,
  parameter int PAYLOAD_WIDTH = hnk_pkg::DEF_PAYLOAD_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  hnk_req_if.sink   req,
  hnk_rsp_if.source rsp,
  hnk_cfg_if.sink   cfg
);
  import hnk_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam int AW = $clog2(CAPACITY);
  localparam int DW = KEY_WIDTH + PAYLOAD_WIDTH;

  logic [COUNT_WIDTH-1:0] capacity_in_use;
  logic                   keep_smallest;

  mem_ctl_t               mctl;
  logic [AW-1:0]          wr_addr;
  logic [DW-1:0]          wr_data;
  logic [AW-1:0]          rd_a_addr;
  logic [AW-1:0]          rd_b_addr;
  logic [DW-1:0]          rd_a_data;
  logic [DW-1:0]          rd_b_data;
  logic [KEY_WIDTH-1:0]   rank_a;
  logic [KEY_WIDTH-1:0]   rank_b;
  logic                   rank_worse;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAPACITY_RESET;
      keep_smallest   <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_CAPACITY: capacity_in_use <= cfg.data;
        CFG_ORDER:    keep_smallest   <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  hnk_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DW)
  ) u_store (
    .clk       (clk),
    .ctl       (mctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  hnk_rank #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_rank (
    .a             (rank_a),
    .b             (rank_b),
    .keep_smallest (keep_smallest),
    .worse         (rank_worse)
  );

  hnk_seq #(
    .CAPACITY      (CAPACITY),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cap        (capacity_in_use),
    .req        (req),
    .rsp        (rsp),
    .mctl       (mctl),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_a_addr  (rd_a_addr),
    .rd_b_addr  (rd_b_addr),
    .rd_a_data  (rd_a_data),
    .rd_b_data  (rd_b_data),
    .rank_a     (rank_a),
    .rank_b     (rank_b),
    .rank_worse (rank_worse)
  );

endmodule
